### design/appa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appa_pkg: shared types and constants of the phantom pixel accumulator
// Item formats, configuration record, register and shape codes, step counts
// of the pipelined divide, square root and power units, and the root table.
// ----------------------------------------------------------------------------
package appa_pkg;

	// Number of grid points along each image axis.
	localparam int GRID_SIZE = 512;

	// APB address width: eight word registers.
	localparam int ADDR_W = 5;

	// Steps of the pipelined units.
	localparam int DIV_STEPS = 22;
	localparam int POW_STEPS = 16;
	localparam int SQ_STEPS  = 17;

	// Front to back queue.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// Shape codes.
	localparam logic [2:0] SHAPE_GAUSS = 3'd0;
	localparam logic [2:0] SHAPE_PARA  = 3'd1;
	localparam logic [2:0] SHAPE_DISK  = 3'd2;
	localparam logic [2:0] SHAPE_QPARA = 3'd3;
	localparam logic [2:0] SHAPE_CONE  = 3'd4;
	localparam logic [2:0] SHAPE_RECT  = 3'd5;
	localparam logic [2:0] SHAPE_NONE  = 3'd6;

	// Register indexes.
	typedef enum logic [2:0] {
		REG_SHAPE_KIND,
		REG_INTENSITY,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_SIZE_A,
		REG_SIZE_B,
		REG_ROTATION_COS,
		REG_ROTATION_SIN
	} reg_idx_t;

	typedef struct packed {
		logic [8:0]         row_index;
		logic [8:0]         col_index;
		logic signed [31:0] prior_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pixel_value;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic [2:0]         shape_kind;
		logic signed [31:0] intensity;
		logic signed [17:0] center_x;
		logic signed [17:0] center_y;
		logic [16:0]        size_a;
		logic [16:0]        size_b;
		logic signed [16:0] rotation_cos;
		logic signed [16:0] rotation_sin;
	} cfg_t;

	// Classified item as it travels through the queue.
	typedef struct packed {
		logic signed [18:0] dx;
		logic signed [18:0] dy;
		logic signed [31:0] prior;
		logic               pass;
	} fr_item_t;

	// Floor integer square root, used to build the constant root table.
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = x;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			bitv = 64'd1 << (2 * i);
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// Factors 2^(-2^-(k+1)) in Q30, each the root of the one before.
	function automatic logic [POW_STEPS*30-1:0] pow_table();
		logic [POW_STEPS*30-1:0] tab;
		logic [63:0]             r;
		tab = '0;
		r   = 64'd1 << 29;
		for (int k = 0; k < POW_STEPS; k++) begin
			r = isqrt64(r << 30);
			tab[k*30 +: 30] = r[29:0];
		end
		return tab;
	endfunction

	localparam logic [POW_STEPS*30-1:0] POW_TAB = pow_table();

endpackage
`default_nettype wire

### design/appa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appa_front: pixel classification
// Maps pixel indices to grid offsets from the shape centre and marks items
// that pass their prior value straight through.
// ----------------------------------------------------------------------------
module appa_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire appa_pkg::in_item_t in_data,
	input  wire appa_pkg::cfg_t    cfg,
	input  wire logic              q_full,
	output logic                   q_push,
	output appa_pkg::fr_item_t     q_wdata
);

	logic [24:0] gx_q16;
	logic [24:0] gy_q16;

	// The queue takes an item whenever it has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Grid coordinate scaled to Q2.15 before the offset of -1.
	assign gx_q16 = {in_data.row_index, 16'b0} / 25'(appa_pkg::GRID_SIZE);
	assign gy_q16 = {in_data.col_index, 16'b0} / 25'(appa_pkg::GRID_SIZE);

	// Offsets from the centre and the pass-through mark.
	always_comb begin
		q_wdata.dx    = $signed({3'b0, gx_q16[15:0]}) - 19'sd32768 - 19'(cfg.center_x);
		q_wdata.dy    = $signed({3'b0, gy_q16[15:0]}) - 19'sd32768 - 19'(cfg.center_y);
		q_wdata.prior = in_data.prior_value;
		q_wdata.pass  = (32'(in_data.row_index) >= appa_pkg::GRID_SIZE)
			|| (32'(in_data.col_index) >= appa_pkg::GRID_SIZE)
			|| (cfg.shape_kind >= appa_pkg::SHAPE_NONE);
	end

endmodule
`default_nettype wire

### design/appa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appa_queue: short item queue
// Four-entry first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module appa_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire appa_pkg::fr_item_t wdata,
	output logic                   full,
	input  wire logic              pop,
	output appa_pkg::fr_item_t     rdata,
	output logic                   empty
);

	appa_pkg::fr_item_t          mem_q [appa_pkg::QUEUE_DEPTH];
	logic [appa_pkg::QUEUE_AW-1:0] wr_q;
	logic [appa_pkg::QUEUE_AW-1:0] rd_q;
	logic [appa_pkg::QUEUE_AW:0]   cnt_q;

	assign full  = (cnt_q == (appa_pkg::QUEUE_AW + 1)'(appa_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/appa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// appa_back: shape evaluation pipeline
// Rotation, pipelined ratio division, parallel power and square root units,
// intensity scaling and the saturating sum. The whole pipe holds while the
// result register waits.
// ----------------------------------------------------------------------------
module appa_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire appa_pkg::cfg_t     cfg,
	input  wire logic               q_empty,
	input  wire appa_pkg::fr_item_t q_rdata,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output appa_pkg::out_item_t     out_data
);

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic               pass;
		logic signed [35:0] p0;
		logic signed [35:0] p1;
		logic signed [35:0] p2;
		logic signed [35:0] p3;
	} mul_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic               pass;
		logic [19:0]        au;
		logic [19:0]        av;
	} rot_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic               pass;
		logic               rect;
		logic [39:0]        au2;
		logic [39:0]        av2;
	} sqr_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [3:0]  low;
		logic [21:0] quo;
	} dstep_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic               pass;
		logic               rect;
		logic               ovfa;
		logic               ovfb;
		dstep_t             da;
		dstep_t             db;
	} div_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic               pass;
		logic               rect;
		logic               sup;
		logic               gz;
		logic [4:0]         n;
		logic [15:0]        f;
		logic [30:0]        p;
		logic [33:0]        arg;
		logic [20:0]        rem;
		logic [16:0]        root;
	} ev_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic [30:0]        op;
	} op_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] prior;
		logic signed [62:0] prod;
	} prd_t;

	// One restoring divide step: bring in one dividend bit.
	function automatic dstep_t div_step(input dstep_t x, input logic [33:0] d);
		dstep_t      y;
		logic [34:0] trial;
		trial = {x.rem, x.low[3]};
		y.low = {x.low[2:0], 1'b0};
		if (trial >= {1'b0, d}) begin
			y.rem = 34'(trial - {1'b0, d});
			y.quo = {x.quo[20:0], 1'b1};
		end else begin
			y.rem = trial[33:0];
			y.quo = {x.quo[20:0], 1'b0};
		end
		return y;
	endfunction

	logic        en;
	logic [16:0] a_eff;
	logic [16:0] b_eff;
	logic [33:0] asq_q;
	logic [33:0] bsq_q;

	mul_t  mul_s1, mul_d;
	rot_t  rot_s2, rot_d;
	sqr_t  sqr_s3, sqr_d;
	div_t  div_s [appa_pkg::DIV_STEPS+1];
	div_t  div_d [appa_pkg::DIV_STEPS+1];
	ev_t   ev0_d;
	ev_t   ev_s [appa_pkg::SQ_STEPS+1];
	ev_t   ev_d [appa_pkg::SQ_STEPS+1];
	op_t   op_s45, op_d;
	prd_t  prd_s46, prd_d;
	logic                res_vld_s47;
	appa_pkg::out_item_t res_s47, res_d;

	// The pipe moves whenever the result register is free or being emptied.
	assign en        = !res_vld_s47 || out_ready;
	assign q_pop     = en && !q_empty;
	assign out_valid = res_vld_s47;
	assign out_data  = res_s47;

	// A zero size counts as one.
	assign a_eff = (cfg.size_a == '0) ? 17'd1 : cfg.size_a;
	assign b_eff = (cfg.size_b == '0) ? 17'd1 : cfg.size_b;

	// Rotation products.
	always_comb begin
		mul_d.vld   = q_pop;
		mul_d.prior = q_rdata.prior;
		mul_d.pass  = q_rdata.pass;
		mul_d.p0    = 36'(q_rdata.dx) * 36'(cfg.rotation_cos);
		mul_d.p1    = 36'(q_rdata.dy) * 36'(cfg.rotation_sin);
		mul_d.p2    = 36'(q_rdata.dy) * 36'(cfg.rotation_cos);
		mul_d.p3    = 36'(q_rdata.dx) * 36'(cfg.rotation_sin);
	end

	// Rotated coordinates, floored to Q2.15, and their magnitudes.
	always_comb begin
		logic signed [36:0] su;
		logic signed [36:0] sv;
		logic signed [21:0] u;
		logic signed [21:0] v;
		su = 37'(mul_s1.p0) + 37'(mul_s1.p1);
		sv = 37'(mul_s1.p2) - 37'(mul_s1.p3);
		u  = 22'(su >>> 15);
		v  = 22'(sv >>> 15);
		rot_d.vld   = mul_s1.vld;
		rot_d.prior = mul_s1.prior;
		rot_d.pass  = mul_s1.pass;
		rot_d.au    = 20'(u[21] ? -u : u);
		rot_d.av    = 20'(v[21] ? -v : v);
	end

	// Squares and the rectangle test.
	always_comb begin
		sqr_d.vld   = rot_s2.vld;
		sqr_d.prior = rot_s2.prior;
		sqr_d.pass  = rot_s2.pass;
		sqr_d.rect  = ({1'b0, rot_s2.au, 1'b0} <= 22'(a_eff))
			&& ({1'b0, rot_s2.av, 1'b0} <= 22'(b_eff));
		sqr_d.au2   = 40'(rot_s2.au) * 40'(rot_s2.au);
		sqr_d.av2   = 40'(rot_s2.av) * 40'(rot_s2.av);
	end

	// Divider load and steps; a ratio of sixteen or more only flags overflow.
	always_comb begin
		div_d[0].vld    = sqr_s3.vld;
		div_d[0].prior  = sqr_s3.prior;
		div_d[0].pass   = sqr_s3.pass;
		div_d[0].rect   = sqr_s3.rect;
		div_d[0].ovfa   = sqr_s3.au2 >= 40'({asq_q, 4'b0});
		div_d[0].ovfb   = sqr_s3.av2 >= 40'({bsq_q, 4'b0});
		div_d[0].da.rem = sqr_s3.au2[37:4];
		div_d[0].da.low = sqr_s3.au2[3:0];
		div_d[0].da.quo = '0;
		div_d[0].db.rem = sqr_s3.av2[37:4];
		div_d[0].db.low = sqr_s3.av2[3:0];
		div_d[0].db.quo = '0;
		for (int i = 0; i < appa_pkg::DIV_STEPS; i++) begin
			div_d[i+1]    = div_s[i];
			div_d[i+1].da = div_step(div_s[i].da, asq_q);
			div_d[i+1].db = div_step(div_s[i].db, bsq_q);
		end
	end

	// Support tests and square root argument from the two ratios.
	always_comb begin
		logic [22:0] t4;
		logic [20:0] t;
		logic [22:0] tsel;
		logic        big;
		logic        sup;
		t4   = 23'(div_s[appa_pkg::DIV_STEPS].da.quo) + 23'(div_s[appa_pkg::DIV_STEPS].db.quo);
		t    = 21'(div_s[appa_pkg::DIV_STEPS].da.quo[21:2])
			+ 21'(div_s[appa_pkg::DIV_STEPS].db.quo[21:2]);
		big  = div_s[appa_pkg::DIV_STEPS].ovfa || div_s[appa_pkg::DIV_STEPS].ovfb;
		tsel = (cfg.shape_kind == appa_pkg::SHAPE_QPARA) ? t4 : 23'(t);
		sup  = !big && (tsel <= 23'd65536);
		ev0_d.vld   = div_s[appa_pkg::DIV_STEPS].vld;
		ev0_d.prior = div_s[appa_pkg::DIV_STEPS].prior;
		ev0_d.pass  = div_s[appa_pkg::DIV_STEPS].pass;
		ev0_d.rect  = div_s[appa_pkg::DIV_STEPS].rect;
		ev0_d.sup   = sup;
		ev0_d.gz    = big || (t4[22:16] > 7'd30);
		ev0_d.n     = t4[20:16];
		ev0_d.f     = t4[15:0];
		ev0_d.p     = 31'h4000_0000;
		ev0_d.rem   = '0;
		ev0_d.root  = '0;
		if (!sup) begin
			ev0_d.arg = '0;
		end else if (cfg.shape_kind == appa_pkg::SHAPE_CONE) begin
			ev0_d.arg = {1'b0, tsel[16:0], 16'b0};
		end else begin
			ev0_d.arg = {1'b0, 17'(17'd65536 - tsel[16:0]), 16'b0};
		end
	end

	// Square root one bit a stage; power of two one fraction bit a stage.
	always_comb begin
		logic [20:0] rem2;
		logic [20:0] trial;
		ev_d[0] = ev0_d;
		for (int i = 0; i < appa_pkg::SQ_STEPS; i++) begin
			ev_d[i+1]     = ev_s[i];
			rem2          = {ev_s[i].rem[18:0], ev_s[i].arg[33:32]};
			trial         = {2'b0, ev_s[i].root, 2'b01};
			ev_d[i+1].arg = {ev_s[i].arg[31:0], 2'b0};
			ev_d[i+1].f   = {ev_s[i].f[14:0], 1'b0};
			if (rem2 >= trial) begin
				ev_d[i+1].rem  = rem2 - trial;
				ev_d[i+1].root = {ev_s[i].root[15:0], 1'b1};
			end else begin
				ev_d[i+1].rem  = rem2;
				ev_d[i+1].root = {ev_s[i].root[15:0], 1'b0};
			end
		end
		for (int i = 0; i < appa_pkg::POW_STEPS; i++) begin
			if (ev_s[i].f[15]) begin
				ev_d[i+1].p = 31'((62'(ev_s[i].p)
					* 62'(appa_pkg::POW_TAB[i*30 +: 30])) >> 30);
			end
		end
	end

	// Profile value in Q30 for the selected shape.
	always_comb begin
		op_d.vld   = ev_s[appa_pkg::SQ_STEPS].vld;
		op_d.prior = ev_s[appa_pkg::SQ_STEPS].prior;
		case (cfg.shape_kind)
			appa_pkg::SHAPE_GAUSS: begin
				op_d.op = ev_s[appa_pkg::SQ_STEPS].gz ? 31'd0
					: 31'(ev_s[appa_pkg::SQ_STEPS].p >> ev_s[appa_pkg::SQ_STEPS].n);
			end
			appa_pkg::SHAPE_PARA, appa_pkg::SHAPE_QPARA: begin
				op_d.op = {ev_s[appa_pkg::SQ_STEPS].root, 14'b0};
			end
			appa_pkg::SHAPE_CONE: begin
				op_d.op = ev_s[appa_pkg::SQ_STEPS].sup
					? {17'(17'd65536 - ev_s[appa_pkg::SQ_STEPS].root), 14'b0} : 31'd0;
			end
			appa_pkg::SHAPE_DISK: begin
				op_d.op = ev_s[appa_pkg::SQ_STEPS].sup ? 31'h4000_0000 : 31'd0;
			end
			appa_pkg::SHAPE_RECT: begin
				op_d.op = ev_s[appa_pkg::SQ_STEPS].rect ? 31'h4000_0000 : 31'd0;
			end
			default: begin
				op_d.op = 31'd0;
			end
		endcase
		if (ev_s[appa_pkg::SQ_STEPS].pass) begin
			op_d.op = 31'd0;
		end
	end

	// Intensity scaling.
	always_comb begin
		prd_d.vld   = op_s45.vld;
		prd_d.prior = op_s45.prior;
		prd_d.prod  = 63'(cfg.intensity) * 63'($signed({1'b0, op_s45.op}));
	end

	// Saturating sum with the prior value.
	always_comb begin
		logic signed [32:0] contrib;
		logic signed [33:0] sum;
		contrib = 33'(prd_s46.prod >>> 30);
		sum     = 34'(prd_s46.prior) + 34'(contrib);
		if (sum > 34'sd2147483647) begin
			res_d.pixel_value = 32'sh7fff_ffff;
			res_d.saturated   = 1'b1;
		end else if (sum < -34'sd2147483648) begin
			res_d.pixel_value = 32'sh8000_0000;
			res_d.saturated   = 1'b1;
		end else begin
			res_d.pixel_value = 32'(sum);
			res_d.saturated   = 1'b0;
		end
	end

	// Pipeline registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asq_q       <= '0;
			bsq_q       <= '0;
			mul_s1      <= '0;
			rot_s2      <= '0;
			sqr_s3      <= '0;
			div_s       <= '{default: '0};
			ev_s        <= '{default: '0};
			op_s45      <= '0;
			prd_s46     <= '0;
			res_vld_s47 <= 1'b0;
			res_s47     <= '0;
		end else begin
			asq_q <= 34'(a_eff) * 34'(a_eff);
			bsq_q <= 34'(b_eff) * 34'(b_eff);
			if (en) begin
				mul_s1      <= mul_d;
				rot_s2      <= rot_d;
				sqr_s3      <= sqr_d;
				div_s       <= div_d;
				ev_s        <= ev_d;
				op_s45      <= op_d;
				prd_s46     <= prd_d;
				res_vld_s47 <= prd_s46.vld;
				res_s47     <= res_d;
			end
		end
	end

	// A clipped result sits at one end of the range.
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s47 && res_s47.saturated |->
			(res_s47.pixel_value == 32'sh7fff_ffff) || (res_s47.pixel_value == 32'sh8000_0000))
		else $error("saturated result not at a range limit");

	// The root of a value no larger than one stays no larger than one.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s[appa_pkg::SQ_STEPS].vld |-> ev_s[appa_pkg::SQ_STEPS].root <= 17'd65536)
		else $error("square root above one");

	// The power product never grows above one.
	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s[appa_pkg::SQ_STEPS].vld |-> ev_s[appa_pkg::SQ_STEPS].p <= 31'h4000_0000)
		else $error("power product above one");

endmodule
`default_nettype wire

### design/analytic_phantom_pixel_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// analytic_phantom_pixel_accumulator_unit: analytic shape pixel accumulator
// Adds the contribution of one configured analytic shape to each pixel item.
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_ready    row_index, col_index, prior_value
//  out       output     out_valid/out_ready  pixel_value, saturated
//  cfg       APB slave  psel/penable/pready  eight registers at 4*index
//
// One item per cycle is sustained while results are taken; the back pipeline
// contains the 22-step ratio divider and the 17-step square root pipeline. A
// four-item queue separates the front from the back; the back pipeline holds
// as a whole while a result waits to be taken. Reset loads the register
// defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module analytic_phantom_pixel_accumulator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire appa_pkg::in_item_t          in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output appa_pkg::out_item_t              out_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [appa_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	appa_pkg::cfg_t     cfg_q;
	appa_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	appa_pkg::fr_item_t q_wdata;
	appa_pkg::fr_item_t q_rdata;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = appa_pkg::reg_idx_t'(paddr[4:2]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_kind   <= appa_pkg::SHAPE_NONE;
			cfg_q.intensity    <= '0;
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.size_a       <= 17'd32768;
			cfg_q.size_b       <= 17'd32768;
			cfg_q.rotation_cos <= 17'sd32768;
			cfg_q.rotation_sin <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				appa_pkg::REG_SHAPE_KIND:   cfg_q.shape_kind   <= pwdata[2:0];
				appa_pkg::REG_INTENSITY:    cfg_q.intensity    <= $signed(pwdata);
				appa_pkg::REG_CENTER_X:     cfg_q.center_x     <= $signed(pwdata[17:0]);
				appa_pkg::REG_CENTER_Y:     cfg_q.center_y     <= $signed(pwdata[17:0]);
				appa_pkg::REG_SIZE_A:       cfg_q.size_a       <= pwdata[16:0];
				appa_pkg::REG_SIZE_B:       cfg_q.size_b       <= pwdata[16:0];
				appa_pkg::REG_ROTATION_COS: cfg_q.rotation_cos <= $signed(pwdata[16:0]);
				appa_pkg::REG_ROTATION_SIN: cfg_q.rotation_sin <= $signed(pwdata[16:0]);
				default: begin
				end
			endcase
		end
	end

	// Register read back, signed registers sign extended.
	always_comb begin
		case (reg_idx)
			appa_pkg::REG_SHAPE_KIND:   prdata = {29'b0, cfg_q.shape_kind};
			appa_pkg::REG_INTENSITY:    prdata = cfg_q.intensity;
			appa_pkg::REG_CENTER_X:     prdata = 32'(cfg_q.center_x);
			appa_pkg::REG_CENTER_Y:     prdata = 32'(cfg_q.center_y);
			appa_pkg::REG_SIZE_A:       prdata = {15'b0, cfg_q.size_a};
			appa_pkg::REG_SIZE_B:       prdata = {15'b0, cfg_q.size_b};
			appa_pkg::REG_ROTATION_COS: prdata = 32'(cfg_q.rotation_cos);
			appa_pkg::REG_ROTATION_SIN: prdata = 32'(cfg_q.rotation_sin);
			default:                    prdata = '0;
		endcase
	end

	// Front: classify items into the queue.
	appa_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Queue between front and back.
	appa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back: evaluate the shape and accumulate.
	appa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### dv/tb_analytic_phantom_pixel_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_analytic_phantom_pixel_accumulator_unit: pixel accumulator testbench
// Sends pixel items through the valid/ready input and programs the shape over
// APB. It predicts each accumulated pixel with its own integer model of the
// profiles and checks every result in order. Random idling on both sides, a
// long output hold-off and a drain pause exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_analytic_phantom_pixel_accumulator_unit;
	import appa_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 80;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// Mirror of the shape registers and the expected pixel results.
	cfg_t                shape_cfg;
	out_item_t           pixel_expected_q[$];
	longint unsigned     root_factor[1:16];
	int                  mismatches = 0;
	int                  pixels_sent = 0;
	int                  pixels_checked = 0;
	int                  cycle_count = 0;
	bit                  idle_enable = 1'b1;
	int                  hold_off_cycles = 0;

	analytic_phantom_pixel_accumulator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor integer square root, digit by digit.
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned probe;
		rem = x;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Sum of squared axis ratios at fraction bits q.
	function automatic longint unsigned axis_ratio(input longint unsigned au,
			input longint unsigned av, input longint unsigned a,
			input longint unsigned b, input int q);
		return ((au * au) << q) / (a * a) + ((av * av) << q) / (b * b);
	endfunction

	// Expected accumulated pixel for one input item under the mirrored shape.
	function automatic out_item_t accumulate_pixel(input in_item_t px);
		out_item_t       res;
		longint          dx, dy, u, v, contrib, total, pw;
		longint unsigned au, av, a, b, t, t4, s, p;
		contrib = 0;
		a = (shape_cfg.size_a == 0) ? 1 : longint'(shape_cfg.size_a);
		b = (shape_cfg.size_b == 0) ? 1 : longint'(shape_cfg.size_b);
		if (px.row_index < GRID_SIZE && px.col_index < GRID_SIZE &&
				shape_cfg.shape_kind < SHAPE_NONE) begin
			dx = -32768 + (longint'(px.row_index) * 65536) / GRID_SIZE
				- longint'(shape_cfg.center_x);
			dy = -32768 + (longint'(px.col_index) * 65536) / GRID_SIZE
				- longint'(shape_cfg.center_y);
			u = (dx * shape_cfg.rotation_cos + dy * shape_cfg.rotation_sin) >>> 15;
			v = (dy * shape_cfg.rotation_cos - dx * shape_cfg.rotation_sin) >>> 15;
			au = (u < 0) ? -u : u;
			av = (v < 0) ? -v : v;
			t = axis_ratio(au, av, a, b, 16);
			t4 = axis_ratio(au, av, a, b, 18);
			case (shape_cfg.shape_kind)
				SHAPE_GAUSS: begin
					p = 64'd1 << 30;
					for (int k = 1; k <= 16; k++)
						if (t4[16-k])
							p = (p * root_factor[k]) >> 30;
					pw = ((t4 >> 16) > 30) ? 0 : longint'(p >> (t4 >> 16));
					contrib = (longint'(shape_cfg.intensity) * pw) >>> 30;
				end
				SHAPE_PARA, SHAPE_QPARA: begin
					if (shape_cfg.shape_kind == SHAPE_QPARA)
						t = t4;
					if (t <= 65536) begin
						s = int_sqrt((65536 - t) << 16);
						contrib = (longint'(shape_cfg.intensity) * longint'(s)) >>> 16;
					end
				end
				SHAPE_DISK: begin
					if (t <= 65536)
						contrib = shape_cfg.intensity;
				end
				SHAPE_CONE: begin
					if (t <= 65536) begin
						s = 65536 - int_sqrt(t << 16);
						contrib = (longint'(shape_cfg.intensity) * longint'(s)) >>> 16;
					end
				end
				default: begin
					if (2 * au <= a && 2 * av <= b)
						contrib = shape_cfg.intensity;
				end
			endcase
		end
		total = longint'(px.prior_value) + contrib;
		res.saturated = 1'b0;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			res.saturated = 1'b1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			res.saturated = 1'b1;
		end
		res.pixel_value = total[31:0];
		return res;
	endfunction

	// Register write over APB, mirrored into the local shape record.
	task automatic write_shape_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SHAPE_KIND:   shape_cfg.shape_kind = value[2:0];
			REG_INTENSITY:    shape_cfg.intensity = value;
			REG_CENTER_X:     shape_cfg.center_x = value[17:0];
			REG_CENTER_Y:     shape_cfg.center_y = value[17:0];
			REG_SIZE_A:       shape_cfg.size_a = value[16:0];
			REG_SIZE_B:       shape_cfg.size_b = value[16:0];
			REG_ROTATION_COS: shape_cfg.rotation_cos = value[16:0];
			default:          shape_cfg.rotation_sin = value[16:0];
		endcase
	endtask

	// Programs all eight registers in one go.
	task automatic load_shape(input logic [2:0] kind, input int c0, input int cx,
			input int cy, input int sa, input int sb, input int cs, input int sn);
		write_shape_reg(REG_SHAPE_KIND, 32'(kind));
		write_shape_reg(REG_INTENSITY, c0);
		write_shape_reg(REG_CENTER_X, cx);
		write_shape_reg(REG_CENTER_Y, cy);
		write_shape_reg(REG_SIZE_A, sa);
		write_shape_reg(REG_SIZE_B, sb);
		write_shape_reg(REG_ROTATION_COS, cs);
		write_shape_reg(REG_ROTATION_SIN, sn);
	endtask

	// Sends one pixel item and records its expected result on acceptance.
	task automatic send_pixel(input logic [8:0] row, input logic [8:0] col,
			input logic [31:0] prior);
		in_item_t px;
		int       gap;
		px.row_index = row;
		px.col_index = col;
		px.prior_value = prior;
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pixel_expected_q.push_back(accumulate_pixel(px));
		pixels_sent++;
		gap = 0;
		if (idle_enable && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	// Lets the input fall idle and waits until every result has arrived.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixel_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_prior();
		case ($urandom_range(0, 5))
			0:       return 32'h7FFF_FFFF - $urandom_range(0, 65536);
			1:       return 32'h8000_0000 + $urandom_range(0, 65536);
			default: return $urandom;
		endcase
	endfunction

	// Output side: random stalls plus an optional long hold-off.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (idle_enable && $urandom_range(0, 6) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 9) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: pixel_value %0d saturated %0d",
						out_data.pixel_value, out_data.saturated);
			end else begin
				want = pixel_expected_q.pop_front();
				pixels_checked++;
				if (out_data.pixel_value !== want.pixel_value ||
						out_data.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: pixel_value exp %0d got %0d, saturated exp %0d got %0d",
							want.pixel_value, out_data.pixel_value,
							want.saturated, out_data.saturated);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("FAIL analytic_phantom_pixel_accumulator_unit");
			$finish;
		end
	end

	// Reset defaults: no shape, so items pass through unchanged.
	task automatic test_reset_defaults();
		send_pixel(9'd0, 9'd0, 32'h7FFF_FFFF);
		send_pixel(9'd511, 9'd511, 32'h8000_0000);
		send_pixel(9'd256, 9'd256, 32'h1234_5678);
		drain_pixels();
	endtask

	// Every shape at its extremes, saturation, zero sizes and odd rotations.
	task automatic test_shapes_directed();
		for (int k = 0; k <= 7; k++) begin
			load_shape(3'(k), 32'h0001_0000, 0, 0, 32768, 16384, 32768, 0);
			send_pixel(9'd256, 9'd256, 32'h0);
			send_pixel(9'd0, 9'd511, 32'h7FFF_FFFF);
			send_pixel(9'd300, 9'd250, 32'h0);
			drain_pixels();
		end
		// Large positive and negative peaks drive the sum into both clips.
		load_shape(SHAPE_DISK, 32'h7FFF_FFFF, 0, 0, 131071, 131071, 32768, 0);
		send_pixel(9'd256, 9'd256, 32'h7FFF_0000);
		drain_pixels();
		write_shape_reg(REG_INTENSITY, 32'h8000_0000);
		send_pixel(9'd256, 9'd256, 32'h8000_FFFF);
		drain_pixels();
		// Zero sizes count as one, with a rotation of half a turn.
		load_shape(SHAPE_RECT, -65536, -131072, 131071, 0, 0, -32768, 0);
		send_pixel(9'd0, 9'd511, 32'h0);
		drain_pixels();
		load_shape(SHAPE_GAUSS, 32'h0100_0000, 0, 0, 1, 131071, 0, 32768);
		send_pixel(9'd256, 9'd256, 32'h0);
		send_pixel(9'd257, 9'd0, 32'h0);
		drain_pixels();
	endtask

	// Random shapes with random pixels; the last phase runs without idling.
	task automatic test_random_shapes(input int phases, input int per_phase);
		real ang;
		int  sa, sb;
		for (int ph = 0; ph < phases; ph++) begin
			ang = $urandom_range(0, 6283) / 1000.0;
			sa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
				: $urandom_range(2048, 65536);
			sb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
				: $urandom_range(2048, 65536);
			if ($urandom_range(0, 3) == 0)
				load_shape(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
					sa, sb, $urandom, $urandom);
			else
				load_shape(3'($urandom_range(0, 5)), $urandom,
					$urandom_range(0, 65536) - 32768, $urandom_range(0, 65536) - 32768,
					sa, sb, $rtoi(32768.0 * $cos(ang)), $rtoi(32768.0 * $sin(ang)));
			if (ph == phases - 1)
				idle_enable = 1'b0;
			for (int i = 0; i < per_phase; i++)
				send_pixel($urandom, $urandom, random_prior());
			drain_pixels();
		end
	endtask

	// Output held off long enough for the input to stall behind it.
	task automatic test_output_hold_off();
		load_shape(SHAPE_CONE, $urandom, 0, 0, 65536, 65536, 32768, 0);
		@(posedge clk);
		hold_off_cycles = 150;
		for (int i = 0; i < 80; i++)
			send_pixel($urandom, $urandom, random_prior());
		drain_pixels();
	endtask

	initial begin
		for (int k = 1; k <= 16; k++)
			root_factor[k] = int_sqrt(((k == 1) ? 64'd1 << 29 : root_factor[k-1]) << 30);
		shape_cfg = '{shape_kind: SHAPE_NONE, intensity: 0, center_x: 0, center_y: 0,
			size_a: 17'd32768, size_b: 17'd32768, rotation_cos: 17'sd32768,
			rotation_sin: 0};
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_shapes_directed();
		test_output_hold_off();
		test_random_shapes(16, 90);
		$display("Covered all shape codes, clipping, zero sizes and rotations over %0d items,",
			pixels_sent);
		$display("with %0d results checked and %0d mismatches.", pixels_checked, mismatches);
		if (mismatches == 0 && pixel_expected_q.size() == 0)
			$display("PASS analytic_phantom_pixel_accumulator_unit");
		else
			$display("FAIL analytic_phantom_pixel_accumulator_unit");
		$finish;
	end

endmodule

### analytic_phantom_pixel_accumulator_unit.f
design/appa_pkg.sv
design/appa_front.sv
design/appa_queue.sv
design/appa_back.sv
design/analytic_phantom_pixel_accumulator_unit.sv
dv/tb_analytic_phantom_pixel_accumulator_unit.sv
